FILE: sv/ssme_pkg.sv
// Shared types and codes for the sorted set merge engine.
// Used by the engine core and the step module; depends on nothing else.
package ssme_pkg;

	// Width of the result count field
	localparam int RES_W = 7;

	// Set operation codes
	localparam logic [1:0] OP_UNION = 2'd0;
	localparam logic [1:0] OP_INTER = 2'd1;
	localparam logic [1:0] OP_DIFF  = 2'd2;
	localparam logic [1:0] OP_DEDUP = 2'd3;

	// Input function codes
	localparam logic [1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [1:0] FUNC_RUN    = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] value;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] value_res;
		logic               is_last;
		logic [RES_W-1:0]   result_count;
		logic               empty_result;
		logic               overflow;
	} out_word_t;

	// Decision of one merge step
	typedef struct packed {
		logic done;
		logic emit;
		logic adv_a;
		logic adv_b;
		logic take_b;
	} step_t;

endpackage

FILE: sv/sorted_set_merge_engine_core.sv
// Sorted set merge engine top level: two list RAMs, merge walker and output register.
// A load fills one list RAM, or sets the overflow flag if that list is full; it emits
// nothing. A run walks the lists twice, once to count and once to emit, one merge step
// per cycle unless the emit pass waits on a stalled output. Input is held off during a run.
// Reset clears counts, overflow flag, operation and control; list RAMs are not cleared.
// Depends on ssme_pkg, ssme_ram and ssme_step.
module sorted_set_merge_engine_core import ssme_pkg::*; #(
	parameter int SET_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_word_t   in_word,
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_word,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data
);

	localparam int CW = $clog2(SET_DEPTH + 1);
	localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_COUNT = 5'b00010,
		S_PRIME = 5'b00100,
		S_EMIT  = 5'b01000,
		S_EMPTY = 5'b10000
	} state_t;

	state_t             state_q;
	logic [1:0]         op_q;
	logic [CW-1:0]      cnt_a_q;
	logic [CW-1:0]      cnt_b_q;
	logic               ovf_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      j_q;
	logic signed [31:0] prev_q;
	logic [RES_W-1:0]   n_q;
	logic [RES_W-1:0]   k_q;
	logic               out_valid_q;
	out_word_t          out_word_q;

	logic               in_acc;
	logic               walking;
	logic               out_free;
	logic               proceed;
	logic               adv_i;
	logic               adv_j;
	logic               finish;
	logic               push;
	logic [CW-1:0]      i_nxt;
	logic [CW-1:0]      j_nxt;
	logic               we_a;
	logic               we_b;
	logic [31:0]        rdata_a;
	logic [31:0]        rdata_b;
	step_t              step;
	out_word_t          push_word;

	// Accept words only while idle
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && (state_q == S_IDLE);

	// Load writes into the list RAMs
	assign we_a = in_acc && (in_word.func == FUNC_LOAD_A) && (cnt_a_q < CW'(SET_DEPTH));
	assign we_b = in_acc && (in_word.func == FUNC_LOAD_B) && (cnt_b_q < CW'(SET_DEPTH));

	// Walk control: count pass always steps, emit pass waits for the output slot
	assign walking  = (state_q == S_COUNT) || (state_q == S_EMIT);
	assign out_free = !out_valid_q || !out_stall;
	assign proceed  = (state_q == S_COUNT) ||
		((state_q == S_EMIT) && (!step.emit || out_free));
	assign adv_i    = walking && proceed && step.adv_a;
	assign adv_j    = walking && proceed && step.adv_b;

	// Next read indexes, rewound at the end of a pass
	always_comb begin
		if (walking && proceed && step.done) begin
			i_nxt = '0;
			j_nxt = '0;
		end else begin
			i_nxt = i_q + CW'(adv_i);
			j_nxt = j_q + CW'(adv_j);
		end
	end

	ssme_ram #(.WIDTH(32), .DEPTH(SET_DEPTH), .AW(AW)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[AW-1:0]),
		.wdata (in_word.value),
		.raddr (i_nxt[AW-1:0]),
		.rdata (rdata_a)
	);

	ssme_ram #(.WIDTH(32), .DEPTH(SET_DEPTH), .AW(AW)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[AW-1:0]),
		.wdata (in_word.value),
		.raddr (j_nxt[AW-1:0]),
		.rdata (rdata_b)
	);

	ssme_step #(.SET_DEPTH(SET_DEPTH)) u_step (
		.op   (op_q),
		.a    (rdata_a),
		.b    (rdata_b),
		.prev (prev_q),
		.i    (i_q),
		.j    (j_q),
		.na   (cnt_a_q),
		.nb   (cnt_b_q),
		.step (step)
	);

	// Build the result word
	always_comb begin
		push_word.overflow = ovf_q;
		if (state_q == S_EMPTY) begin
			push_word.value_res    = '0;
			push_word.is_last      = 1'b1;
			push_word.result_count = '0;
			push_word.empty_result = 1'b1;
			push = out_free;
		end else begin
			push_word.value_res    = step.take_b ? rdata_b : rdata_a;
			push_word.is_last      = (RES_W'(k_q + RES_W'(1)) == n_q);
			push_word.result_count = n_q;
			push_word.empty_result = 1'b0;
			push = (state_q == S_EMIT) && step.emit && out_free;
		end
	end

	assign finish = ((state_q == S_EMIT) && proceed && step.done) ||
		((state_q == S_EMPTY) && out_free);

	// Sequencer, counts and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_UNION;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			n_q     <= '0;
			k_q     <= '0;
		end else begin
			i_q <= i_nxt;
			j_q <= j_nxt;
			if (cfg_we) begin
				op_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_word.func)
							FUNC_LOAD_A: begin
								if (we_a) cnt_a_q <= cnt_a_q + CW'(1);
								else ovf_q <= 1'b1;
							end
							FUNC_LOAD_B: begin
								if (we_b) cnt_b_q <= cnt_b_q + CW'(1);
								else ovf_q <= 1'b1;
							end
							FUNC_RUN: begin
								state_q <= S_COUNT;
								n_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				S_COUNT: begin
					if (step.done) begin
						state_q <= (n_q == '0) ? S_EMPTY : S_PRIME;
						k_q     <= '0;
					end else if (step.emit) begin
						n_q <= n_q + RES_W'(1);
					end
				end
				S_PRIME: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (push) begin
						k_q <= k_q + RES_W'(1);
					end
				end
				S_EMPTY: ;
				default: state_q <= S_IDLE;
			endcase
			// Drop the lists once the run is delivered
			if (finish) begin
				state_q <= S_IDLE;
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// Hold the previous first-list value for dedup
	always_ff @(posedge clk) begin
		if (adv_i) begin
			prev_q <= rdata_a;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_word_q <= push_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// An empty-result word is the only and last word of its run
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.empty_result) |->
			(out_word_q.is_last && (out_word_q.result_count == '0)))
		else $error("empty result word malformed");

	// Never push more words than counted
	a_push_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (state_q == S_EMIT)) |-> (k_q < n_q))
		else $error("emit pass pushed beyond count");

	// The emit pass ends exactly after the last word
	a_emit_complete: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT) && proceed && step.done) |-> (k_q == n_q))
		else $error("emit pass ended with words missing");

	// Lists are cleared after a run
	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> ((cnt_a_q == '0) && (cnt_b_q == '0) && !ovf_q))
		else $error("counts not cleared after run");

endmodule

FILE: sv/ssme_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
module ssme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/ssme_step.sv
// Merge step: compares the heads (dedup: head and prev) and picks what to emit.
// Depends on ssme_pkg for operation codes and the step_t struct.
module ssme_step import ssme_pkg::*; #(
	parameter int SET_DEPTH = 32,
	localparam int CW = $clog2(SET_DEPTH + 1)
) (
	input  logic [1:0]         op,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic signed [31:0] prev,
	input  logic [CW-1:0]      i,
	input  logic [CW-1:0]      j,
	input  logic [CW-1:0]      na,
	input  logic [CW-1:0]      nb,
	output step_t              step
);

	logic ha;
	logic hb;

	assign ha = i < na;
	assign hb = j < nb;

	// Decide emit and advance for the current heads
	always_comb begin
		step = '0;
		priority if (op == OP_DEDUP) begin
			if (!ha) begin
				step.done = 1'b1;
			end else begin
				step.adv_a = 1'b1;
				step.emit  = (i == '0) || (a != prev);
			end
		end else if (ha && hb) begin
			priority if (a < b) begin
				step.adv_a = 1'b1;
				step.emit  = (op != OP_INTER);
			end else if (b < a) begin
				step.adv_b  = 1'b1;
				step.take_b = 1'b1;
				step.emit   = (op == OP_UNION);
			end else begin
				step.adv_a = 1'b1;
				step.adv_b = 1'b1;
				step.emit  = (op != OP_DIFF);
			end
		end else if (ha) begin
			if (op == OP_INTER) begin
				step.done = 1'b1;
			end else begin
				step.adv_a = 1'b1;
				step.emit  = 1'b1;
			end
		end else if (hb) begin
			if (op == OP_UNION) begin
				step.adv_b  = 1'b1;
				step.take_b = 1'b1;
				step.emit   = 1'b1;
			end else begin
				step.done = 1'b1;
			end
		end else begin
			step.done = 1'b1;
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for sorted_set_merge_engine_core: list loads, runs under all four
// set operations, overflow, empty results, random input gaps and random output stalls.
// Depends on ssme_pkg and the engine RTL.
`timescale 1ns / 100ps

module tb_top;
	import ssme_pkg::*;

	localparam int SET_DEPTH      = 32;
	localparam int DRAIN_CYCLES   = 160;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_word_t   in_word = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_word_t  out_word;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_data = 2'd0;

	// Predictor state: loaded lists, counts, overflow flag and current operation
	logic signed [31:0] list_a [SET_DEPTH];
	logic signed [31:0] list_b [SET_DEPTH];
	int         cnt_a = 0;
	int         cnt_b = 0;
	logic       ovf_seen = 1'b0;
	logic [1:0] cur_op = OP_UNION;

	out_word_t  merge_results_q [$];
	in_word_t   pending_words [$];
	int         words_queued = 0;
	int         words_accepted = 0;
	int         err_count = 0;

	int         send_gap = 0;
	int         stall_left = 0;
	int         hold_left = 0;
	bit         hold_armed = 1'b0;
	bit         hold_done = 1'b0;
	bit         quiet_tail = 1'b0;
	int         idle_cycles = 0;

	sorted_set_merge_engine_core #(.SET_DEPTH(SET_DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one accepted word to the predictor; a run pushes the merged list
	function automatic void merge_predict(input in_word_t w);
		logic signed [31:0] res [$];
		out_word_t r;
		int i;
		int j;
		int k;
		int n;
		i = 0;
		j = 0;
		case (w.func)
			FUNC_LOAD_A: begin
				if (cnt_a < SET_DEPTH) begin
					list_a[cnt_a] = w.value;
					cnt_a++;
				end else
					ovf_seen = 1'b1;
			end
			FUNC_LOAD_B: begin
				if (cnt_b < SET_DEPTH) begin
					list_b[cnt_b] = w.value;
					cnt_b++;
				end else
					ovf_seen = 1'b1;
			end
			FUNC_RUN: begin
				if (cur_op == OP_DEDUP) begin
					// keep the first of each run of equal neighbors
					while (i < cnt_a) begin
						if (i == 0 || list_a[i-1] != list_a[i])
							res.push_back(list_a[i]);
						i++;
					end
				end else begin
					// walk both lists with signed compares
					while (i < cnt_a && j < cnt_b) begin
						if (list_a[i] < list_b[j]) begin
							if (cur_op != OP_INTER)
								res.push_back(list_a[i]);
							i++;
						end else if (list_b[j] < list_a[i]) begin
							if (cur_op == OP_UNION)
								res.push_back(list_b[j]);
							j++;
						end else begin
							if (cur_op != OP_DIFF)
								res.push_back(list_a[i]);
							i++;
							j++;
						end
					end
					if (cur_op != OP_INTER) begin
						while (i < cnt_a) begin
							res.push_back(list_a[i]);
							i++;
						end
					end
					if (cur_op == OP_UNION) begin
						while (j < cnt_b) begin
							res.push_back(list_b[j]);
							j++;
						end
					end
				end
				n = res.size();
				if (n == 0) begin
					r.value_res    = '0;
					r.is_last      = 1'b1;
					r.result_count = '0;
					r.empty_result = 1'b1;
					r.overflow     = ovf_seen;
					merge_results_q.push_back(r);
				end else begin
					for (k = 0; k < n; k++) begin
						r.value_res    = res[k];
						r.is_last      = (k == n - 1);
						r.result_count = RES_W'(n);
						r.empty_result = 1'b0;
						r.overflow     = ovf_seen;
						merge_results_q.push_back(r);
					end
				end
				cnt_a = 0;
				cnt_b = 0;
				ovf_seen = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// Compare one result word with the oldest expectation
	task automatic check_result(input out_word_t got);
		out_word_t want;
		if (merge_results_q.size() == 0) begin
			$error("unexpected result word: value_res %0d", got.value_res);
			err_count++;
		end else begin
			want = merge_results_q.pop_front();
			if (got.value_res !== want.value_res) begin
				$error("value_res: expected %0d, actual %0d", want.value_res, got.value_res);
				err_count++;
			end
			if (got.is_last !== want.is_last) begin
				$error("is_last: expected %0d, actual %0d", want.is_last, got.is_last);
				err_count++;
			end
			if (got.result_count !== want.result_count) begin
				$error("result_count: expected %0d, actual %0d", want.result_count,
					got.result_count);
				err_count++;
			end
			if (got.empty_result !== want.empty_result) begin
				$error("empty_result: expected %0d, actual %0d", want.empty_result,
					got.empty_result);
				err_count++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
				err_count++;
			end
		end
	endtask

	// Driver: offer pending words, hold each until accepted, insert random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				merge_predict(in_word);
				words_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (!quiet_tail && pending_words.size() != 0 &&
						$urandom_range(0, 5) == 0) begin
					in_valid <= 1'b0;
					send_gap <= $urandom_range(0, 15);
				end else if (pending_words.size() != 0) begin
					in_word  <= pending_words.pop_front();
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check accepted result words, drive random and long stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_result(out_word);
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_armed && !hold_done && out_valid) begin
				out_stall <= 1'b1;
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
			end else if (stall_left != 0) begin
				out_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 15);
			end else
				out_stall <= 1'b0;
		end
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_word(input logic [1:0] func, input logic signed [31:0] value);
		in_word_t w;
		w.func  = func;
		w.value = value;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// Write the operation register; only called while the engine is idle
	task automatic write_op(input logic [1:0] op);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= op;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_op = op;
	endtask

	// Wait for every word to be taken and every result to come back, then settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (words_accepted != words_queued || merge_results_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int rand_step();
		case ($urandom_range(0, 2))
			0:       return 3;
			1:       return 1000;
			default: return 'h3FF_FFFF;
		endcase
	endfunction

	// Queue two lists sharing a start point, loads interleaved, then a run
	task automatic queue_set(input int na, input int nb, input int step, input bit ordered);
		logic signed [31:0] va [34];
		logic signed [31:0] vb [34];
		logic signed [31:0] t;
		longint lo;
		longint hi;
		longint cur_a;
		longint cur_b;
		int ia;
		int ib;
		lo = -64'sd2147483648;
		hi = 64'sd2147483647 - 64'sd34 * step;
		cur_a = lo + longint'($urandom()) % (hi - lo + 1);
		cur_b = cur_a;
		for (ia = 0; ia < na; ia++) begin
			cur_a += $urandom_range(0, step);
			va[ia] = cur_a[31:0];
		end
		for (ib = 0; ib < nb; ib++) begin
			cur_b += $urandom_range(0, step);
			vb[ib] = cur_b[31:0];
		end
		// break the order of the first list
		if (!ordered && na >= 2) begin
			t = va[0];
			va[0] = va[na-1];
			va[na-1] = t;
		end
		ia = 0;
		ib = 0;
		while (ia < na || ib < nb) begin
			if ($urandom_range(0, 15) == 0)
				push_word(FUNC_UNUSED, $urandom());
			if (ib == nb || (ia < na && $urandom_range(0, 1) == 0)) begin
				push_word(FUNC_LOAD_A, va[ia]);
				ia++;
			end else begin
				push_word(FUNC_LOAD_B, vb[ib]);
				ib++;
			end
		end
		push_word(FUNC_RUN, $urandom());
	endtask

	task automatic queue_random_sets(input int count);
		repeat (count)
			queue_set($urandom_range(0, 6), $urandom_range(0, 6), rand_step(),
				$urandom_range(0, 7) != 0);
	endtask

	initial begin
		logic [1:0] tail_op;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Union: empty run, extremes with equal values, unused function code
		write_op(OP_UNION);
		push_word(FUNC_RUN, 32'sd0);
		push_word(FUNC_LOAD_A, -32'sd2147483648);
		push_word(FUNC_LOAD_A, -32'sd1);
		push_word(FUNC_LOAD_A, 32'sd2147483647);
		push_word(FUNC_LOAD_B, -32'sd2147483648);
		push_word(FUNC_LOAD_B, 32'sd5);
		push_word(FUNC_LOAD_B, 32'sd2147483647);
		push_word(FUNC_RUN, -32'sd1);
		push_word(FUNC_UNUSED, -32'sd1);
		wait_drained();

		// Intersection with repeated values; long receiver hold in this phase
		write_op(OP_INTER);
		push_word(FUNC_LOAD_A, 32'sd1);
		push_word(FUNC_LOAD_A, 32'sd2);
		push_word(FUNC_LOAD_A, 32'sd2);
		push_word(FUNC_LOAD_A, 32'sd3);
		push_word(FUNC_LOAD_B, 32'sd2);
		push_word(FUNC_LOAD_B, 32'sd4);
		push_word(FUNC_RUN, 32'sd0);
		hold_armed = 1'b1;
		queue_random_sets(1);
		wait_drained();

		// Difference with an unsorted first list
		write_op(OP_DIFF);
		push_word(FUNC_LOAD_A, 32'sd5);
		push_word(FUNC_LOAD_A, 32'sd1);
		push_word(FUNC_LOAD_A, 32'sd3);
		push_word(FUNC_LOAD_B, 32'sd1);
		push_word(FUNC_LOAD_B, 32'sd3);
		push_word(FUNC_RUN, 32'sd0);
		queue_random_sets(1);
		wait_drained();

		// Dedup; the second list must not matter
		write_op(OP_DEDUP);
		push_word(FUNC_LOAD_A, 32'sd7);
		push_word(FUNC_LOAD_A, 32'sd7);
		push_word(FUNC_LOAD_A, -32'sd3);
		push_word(FUNC_LOAD_A, -32'sd3);
		push_word(FUNC_LOAD_B, 32'sd1);
		push_word(FUNC_RUN, 32'sd0);
		queue_random_sets(1);
		wait_drained();

		// Full stores plus one dropped load: largest result with overflow
		write_op(OP_UNION);
		queue_set(SET_DEPTH + 1, SET_DEPTH, 'h3FF_FFFF, 1'b1);
		wait_drained();

		// Tail without idling on either side
		tail_op = $urandom_range(0, 3);
		write_op(tail_op);
		quiet_tail = 1'b1;
		queue_random_sets(2);
		wait_drained();

		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
